@@ hdl/cpr_pkg.sv @@
// cpr_pkg: shared types and constants of the convex polygon row mask block
`default_nettype none

package cpr_pkg;

   localparam int FIELD_COORD_BITS = 16;
   localparam int FIELD_ROW_BITS   = 15;
   localparam int CSR_DATA_BITS    = 15;
   localparam int CSR_INDEX_BITS   = 1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic [CSR_DATA_BITS-1:0] WIDTH_RESET  = 15'd640;
   localparam logic [CSR_DATA_BITS-1:0] HEIGHT_RESET = 15'd480;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WALK_CHECK,
      ST_READ,
      ST_TEST,
      ST_MUL_A,
      ST_MUL_B,
      ST_DIV_SETUP,
      ST_DIV,
      ST_STORE,
      ST_SIDE_END,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic load_en;
      logic query_start;
      logic step_next;
      logic capture_span;
      logic mul_a;
      logic mul_b;
      logic div_start;
      logic div_step;
      logic store_col;
      logic next_side;
      logic result_load;
   } cmd_type;

   typedef struct packed {
      logic early_done;
      logic walk_end;
      logic span_hit;
      logic div_last;
      logic right_side;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

@@ hdl/convex_polygon_outside_row_mask.sv @@
// convex_polygon_outside_row_mask: top level of the polygon row mask block
`default_nettype none

// Loads are taken while idle and leave the controller idle. A query that falls on a whole
// row, on a row outside the image or on an empty polygon goes straight to the result.
// Otherwise each side walks its chain from the top vertex, reading and testing one edge
// at a time (the vertex memory has a registered read), and on the spanning edge uses the
// shared multiplier and then the bit-serial divider before it finishes the side; a side
// whose chain holds no spanning edge ends when its walk reaches the bottom vertex or has
// examined every edge. Inputs are taken only while no query is in progress; a finished
// result sits in an output register, so loads and the next query are accepted while it
// waits to be taken.

module convex_polygon_outside_row_mask #(
   parameter int MAX_CORNERS = 64,
   parameter int COORD_BITS  = 16
) (
   input  wire                                         clock,
   input  wire                                         reset,
   // configuration writes
   input  wire                                         csr_write,
   input  wire  [cpr_pkg::CSR_INDEX_BITS-1:0]          csr_index,
   input  wire  [cpr_pkg::CSR_DATA_BITS-1:0]           csr_data,
   // request transactions
   input  wire                                         req_valid,
   output logic                                        req_stall,
   input  wire                                         req_mode,
   input  wire                                         req_first_vertex,
   input  wire  signed [cpr_pkg::FIELD_COORD_BITS-1:0] req_vertex_x,
   input  wire  signed [cpr_pkg::FIELD_COORD_BITS-1:0] req_vertex_y,
   input  wire  [cpr_pkg::FIELD_ROW_BITS-1:0]          req_query_row,
   // response transactions
   output logic                                        rsp_valid,
   input  wire                                         rsp_stall,
   output logic [cpr_pkg::FIELD_ROW_BITS-1:0]          rsp_row,
   output logic                                        rsp_whole_row,
   output logic                                        rsp_left_valid,
   output logic signed [cpr_pkg::FIELD_COORD_BITS-1:0] rsp_left_end,
   output logic                                        rsp_right_valid,
   output logic signed [cpr_pkg::FIELD_COORD_BITS-1:0] rsp_right_start
);

   cpr_pkg::cmd_type    cmd;
   cpr_pkg::status_type status;

   // controller: accepts transactions and steps the walk and divider
   cpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: vertex memory, interpolation, result register
   cpr_datapath #(
      .MAX_CORNERS (MAX_CORNERS),
      .COORD_BITS  (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_first_vertex (req_first_vertex),
      .req_vertex_x     (req_vertex_x),
      .req_vertex_y     (req_vertex_y),
      .req_query_row    (req_query_row),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row          (rsp_row),
      .rsp_whole_row    (rsp_whole_row),
      .rsp_left_valid   (rsp_left_valid),
      .rsp_left_end     (rsp_left_end),
      .rsp_right_valid  (rsp_right_valid),
      .rsp_right_start  (rsp_right_start)
   );

endmodule

`default_nettype wire

@@ hdl/cpr_ctrl.sv @@
// cpr_ctrl: sequencing state machine for loads, chain walks and division
`default_nettype none

module cpr_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire                   req_mode,
   output logic                  req_stall,
   input  cpr_pkg::status_type   status,
   output cpr_pkg::cmd_type      cmd
);

   cpr_pkg::state_type state_ff;
   cpr_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cpr_pkg::ST_IDLE: begin
            if (req_valid && req_mode == cpr_pkg::MODE_QUERY) begin
               state_in = status.early_done ? cpr_pkg::ST_RESULT : cpr_pkg::ST_WALK_CHECK;
            end
         end
         cpr_pkg::ST_WALK_CHECK: begin
            state_in = status.walk_end ? cpr_pkg::ST_SIDE_END : cpr_pkg::ST_READ;
         end
         cpr_pkg::ST_READ:      state_in = cpr_pkg::ST_TEST;
         cpr_pkg::ST_TEST: begin
            state_in = status.span_hit ? cpr_pkg::ST_MUL_A : cpr_pkg::ST_WALK_CHECK;
         end
         cpr_pkg::ST_MUL_A:     state_in = cpr_pkg::ST_MUL_B;
         cpr_pkg::ST_MUL_B:     state_in = cpr_pkg::ST_DIV_SETUP;
         cpr_pkg::ST_DIV_SETUP: state_in = cpr_pkg::ST_DIV;
         cpr_pkg::ST_DIV: begin
            if (status.div_last) begin
               state_in = cpr_pkg::ST_STORE;
            end
         end
         cpr_pkg::ST_STORE:     state_in = cpr_pkg::ST_SIDE_END;
         cpr_pkg::ST_SIDE_END: begin
            state_in = status.right_side ? cpr_pkg::ST_RESULT : cpr_pkg::ST_WALK_CHECK;
         end
         cpr_pkg::ST_RESULT: begin
            if (status.out_free) begin
               state_in = cpr_pkg::ST_IDLE;
            end
         end
         default:               state_in = cpr_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         cpr_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_en     = (req_mode == cpr_pkg::MODE_LOAD);
               cmd.query_start = (req_mode == cpr_pkg::MODE_QUERY);
            end
         end
         cpr_pkg::ST_TEST: begin
            cmd.capture_span = status.span_hit;
            cmd.step_next    = !status.span_hit;
         end
         cpr_pkg::ST_MUL_A:     cmd.mul_a = 1'b1;
         cpr_pkg::ST_MUL_B:     cmd.mul_b = 1'b1;
         cpr_pkg::ST_DIV_SETUP: cmd.div_start = 1'b1;
         cpr_pkg::ST_DIV:       cmd.div_step = 1'b1;
         cpr_pkg::ST_STORE:     cmd.store_col = 1'b1;
         cpr_pkg::ST_SIDE_END:  cmd.next_side = 1'b1;
         cpr_pkg::ST_RESULT:    cmd.result_load = status.out_free;
         default:               cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

@@ hdl/cpr_datapath.sv @@
// cpr_datapath: vertex store, chain walk, interpolation and result register
`default_nettype none

module cpr_datapath #(
   parameter int MAX_CORNERS = 64,
   parameter int COORD_BITS  = 16
) (
   input  wire                                         clock,
   input  wire                                         reset,
   input  cpr_pkg::cmd_type                            cmd,
   output cpr_pkg::status_type                         status,
   input  wire                                         csr_write,
   input  wire  [cpr_pkg::CSR_INDEX_BITS-1:0]          csr_index,
   input  wire  [cpr_pkg::CSR_DATA_BITS-1:0]           csr_data,
   input  wire                                         req_first_vertex,
   input  wire  signed [cpr_pkg::FIELD_COORD_BITS-1:0] req_vertex_x,
   input  wire  signed [cpr_pkg::FIELD_COORD_BITS-1:0] req_vertex_y,
   input  wire  [cpr_pkg::FIELD_ROW_BITS-1:0]          req_query_row,
   output logic                                        rsp_valid,
   input  wire                                         rsp_stall,
   output logic [cpr_pkg::FIELD_ROW_BITS-1:0]          rsp_row,
   output logic                                        rsp_whole_row,
   output logic                                        rsp_left_valid,
   output logic signed [cpr_pkg::FIELD_COORD_BITS-1:0] rsp_left_end,
   output logic                                        rsp_right_valid,
   output logic signed [cpr_pkg::FIELD_COORD_BITS-1:0] rsp_right_start
);

   localparam int AW   = $clog2(MAX_CORNERS);
   localparam int CW   = $clog2(MAX_CORNERS + 1);
   localparam int EXT  = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;
   localparam int DW   = COORD_BITS + 1;
   localparam int PW   = 2 * COORD_BITS + 1;
   localparam int NW   = 2 * COORD_BITS + 2;
   localparam int QCW  = $clog2(NW + 1);
   localparam int FW   = cpr_pkg::FIELD_COORD_BITS;
   localparam int RWB  = cpr_pkg::FIELD_ROW_BITS;

   // vertex store
   logic signed [COORD_BITS-1:0] corner_x_mem [MAX_CORNERS];
   logic signed [COORD_BITS-1:0] corner_y_mem [MAX_CORNERS];

   logic [RWB-1:0]  width_ff, width_in, height_ff, height_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [AW-1:0]   top_ff, top_in, bottom_ff, bottom_in;
   logic signed [COORD_BITS-1:0] top_y_ff, top_y_in, bottom_y_ff, bottom_y_in;

   logic [AW-1:0]   idx_i_ff, idx_i_in;
   logic [CW-1:0]   steps_ff, steps_in;
   logic            side_ff, side_in;
   logic [RWB-1:0]  row_ff, row_in;

   logic signed [COORD_BITS-1:0] rd_xi_ff, rd_yi_ff, rd_xj_ff, rd_yj_ff;
   logic signed [COORD_BITS-1:0] xt_ff, xt_in, xb_ff, xb_in;
   logic signed [DW-1:0]         dist_a_ff, dist_a_in, dist_b_ff, dist_b_in;
   logic [DW-1:0]                den_ff, den_in;
   logic signed [NW-1:0]         acc_ff, acc_in;
   logic [NW-1:0]                quo_ff, quo_in;
   logic [DW-1:0]                rem_ff, rem_in;
   logic                         neg_ff, neg_in;
   logic [QCW-1:0]               qcnt_ff, qcnt_in;

   logic                 whole_ff, whole_in, lv_ff, lv_in, rv_ff, rv_in;
   logic signed [FW-1:0] le_ff, le_in, rs_ff, rs_in;

   logic                 out_valid_ff, out_valid_in;
   logic [RWB-1:0]       out_row_ff, out_row_in;
   logic                 out_whole_ff, out_whole_in, out_lv_ff, out_lv_in;
   logic                 out_rv_ff, out_rv_in;
   logic signed [FW-1:0] out_le_ff, out_le_in, out_rs_ff, out_rs_in;

   // combinational helpers
   logic signed [COORD_BITS-1:0] new_x, new_y;
   logic                         restart, store_full, load_do;
   logic [CW-1:0]                load_k;
   logic signed [EXT-1:0]        w_ext, h_ext, q_ext, r_ext, ty_ext, by_ext;
   logic signed [EXT-1:0]        yt_ext, yb_ext;
   logic                         in_range, whole_cond;
   logic [CW-1:0]                i_cw, j_cw;
   logic [AW-1:0]                idx_j;
   logic signed [COORD_BITS-1:0] mul_x;
   logic signed [DW-1:0]         mul_d;
   logic signed [PW-1:0]         prod;
   logic [DW-1:0]                rem_sh;
   logic                         rem_ge;
   logic signed [NW-1:0]         quo_signed;
   logic signed [EXT-1:0]        col;
   logic                         col_ok;

   assign new_x      = COORD_BITS'(req_vertex_x);
   assign new_y      = COORD_BITS'(req_vertex_y);
   assign restart    = req_first_vertex || (count_ff == '0);
   assign store_full = count_ff == CW'(MAX_CORNERS);
   assign load_do    = cmd.load_en && (restart || !store_full);
   assign load_k     = restart ? '0 : count_ff;

   assign w_ext  = EXT'(signed'({1'b0, width_ff}));
   assign h_ext  = EXT'(signed'({1'b0, height_ff}));
   assign q_ext  = EXT'(signed'({1'b0, req_query_row}));
   assign r_ext  = EXT'(signed'({1'b0, row_ff}));
   assign ty_ext = EXT'(top_y_ff);
   assign by_ext = EXT'(bottom_y_ff);
   assign yt_ext = EXT'(rd_yi_ff);
   assign yb_ext = EXT'(rd_yj_ff);

   // early outcome of a query: no polygon, outside the image, or whole row
   assign in_range   = (count_ff != '0) && (q_ext < h_ext);
   assign whole_cond = in_range &&
                       ((q_ext < ty_ext) || ((by_ext < h_ext - 1) && (q_ext >= by_ext)));

   // neighbor along the chain: side 0 walks backward, side 1 forward
   assign i_cw  = CW'(idx_i_ff);
   assign j_cw  = side_ff ? ((i_cw + 1'b1 == count_ff) ? '0 : i_cw + 1'b1)
                          : ((i_cw == '0) ? count_ff - 1'b1 : i_cw - 1'b1);
   assign idx_j = j_cw[AW-1:0];

   assign mul_x = cmd.mul_a ? xt_ff : xb_ff;
   assign mul_d = cmd.mul_a ? dist_a_ff : dist_b_ff;
   assign prod  = PW'(mul_x) * PW'(mul_d);

   assign rem_sh = {rem_ff[DW-2:0], quo_ff[NW-1]};
   assign rem_ge = rem_sh >= den_ff;

   assign quo_signed = neg_ff ? -signed'(quo_ff) : signed'(quo_ff);
   assign col        = EXT'(quo_signed);
   assign col_ok     = (col > 0) && (col < w_ext - 1);

   assign status.early_done = !in_range || whole_cond;
   assign status.walk_end   = (idx_i_ff == bottom_ff) || (steps_ff >= count_ff);
   assign status.span_hit   = (yt_ext < yb_ext) && (r_ext >= yt_ext) && (r_ext < yb_ext);
   assign status.div_last   = qcnt_ff == QCW'(NW - 1);
   assign status.right_side = side_ff;
   assign status.out_free   = !out_valid_ff || !rsp_stall;

   // memory write and registered two-port read
   always_ff @(posedge clock) begin
      if (load_do) begin
         corner_x_mem[load_k[AW-1:0]] <= new_x;
         corner_y_mem[load_k[AW-1:0]] <= new_y;
      end
      rd_xi_ff <= corner_x_mem[idx_i_ff];
      rd_yi_ff <= corner_y_mem[idx_i_ff];
      rd_xj_ff <= corner_x_mem[idx_j];
      rd_yj_ff <= corner_y_mem[idx_j];
   end

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      count_in    = count_ff;
      top_in      = top_ff;
      bottom_in   = bottom_ff;
      top_y_in    = top_y_ff;
      bottom_y_in = bottom_y_ff;
      idx_i_in    = idx_i_ff;
      steps_in    = steps_ff;
      side_in     = side_ff;
      row_in      = row_ff;
      xt_in       = xt_ff;
      xb_in       = xb_ff;
      dist_a_in   = dist_a_ff;
      dist_b_in   = dist_b_ff;
      den_in      = den_ff;
      acc_in      = acc_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      neg_in      = neg_ff;
      qcnt_in     = qcnt_ff;
      whole_in    = whole_ff;
      lv_in       = lv_ff;
      rv_in       = rv_ff;
      le_in       = le_ff;
      rs_in       = rs_ff;

      if (csr_write) begin
         case (csr_index)
            cpr_pkg::REG_IMAGE_WIDTH:  width_in  = csr_data;
            cpr_pkg::REG_IMAGE_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end

      if (load_do) begin
         count_in = load_k + 1'b1;
         if (restart) begin
            top_in      = '0;
            bottom_in   = '0;
            top_y_in    = new_y;
            bottom_y_in = new_y;
         end else begin
            if (new_y < top_y_ff) begin
               top_in   = load_k[AW-1:0];
               top_y_in = new_y;
            end
            if (new_y > bottom_y_ff) begin
               bottom_in   = load_k[AW-1:0];
               bottom_y_in = new_y;
            end
         end
      end

      if (cmd.query_start) begin
         row_in   = req_query_row;
         whole_in = whole_cond;
         lv_in    = 1'b0;
         rv_in    = 1'b0;
         le_in    = '0;
         rs_in    = '0;
         side_in  = 1'b0;
         idx_i_in = top_ff;
         steps_in = '0;
      end

      if (cmd.next_side) begin
         side_in  = 1'b1;
         idx_i_in = top_ff;
         steps_in = '0;
      end

      if (cmd.step_next) begin
         idx_i_in = idx_j;
         steps_in = steps_ff + 1'b1;
      end

      // num = xt*(yb-r) + xb*(r-yt), exact edge interpolation numerator
      if (cmd.capture_span) begin
         xt_in     = rd_xi_ff;
         xb_in     = rd_xj_ff;
         dist_a_in = DW'(yb_ext - r_ext);
         dist_b_in = DW'(r_ext - yt_ext);
         den_in    = DW'(yb_ext - yt_ext);
      end

      if (cmd.mul_a) begin
         acc_in = NW'(prod);
      end
      if (cmd.mul_b) begin
         acc_in = acc_ff + NW'(prod);
      end

      if (cmd.div_start) begin
         neg_in  = acc_ff[NW-1];
         quo_in  = acc_ff[NW-1] ? unsigned'(-acc_ff) : unsigned'(acc_ff);
         rem_in  = '0;
         qcnt_in = '0;
      end

      // restoring divider, one quotient bit per cycle
      if (cmd.div_step) begin
         rem_in  = rem_ge ? rem_sh - den_ff : rem_sh;
         quo_in  = {quo_ff[NW-2:0], rem_ge};
         qcnt_in = qcnt_ff + 1'b1;
      end

      if (cmd.store_col && col_ok) begin
         if (side_ff) begin
            rv_in = 1'b1;
            rs_in = col[FW-1:0];
         end else begin
            lv_in = 1'b1;
            le_in = col[FW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= cpr_pkg::WIDTH_RESET;
         height_ff <= cpr_pkg::HEIGHT_RESET;
         count_ff  <= '0;
         top_ff    <= '0;
         bottom_ff <= '0;
         idx_i_ff  <= '0;
         steps_ff  <= '0;
         side_ff   <= 1'b0;
         qcnt_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         count_ff  <= count_in;
         top_ff    <= top_in;
         bottom_ff <= bottom_in;
         idx_i_ff  <= idx_i_in;
         steps_ff  <= steps_in;
         side_ff   <= side_in;
         qcnt_ff   <= qcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      top_y_ff    <= top_y_in;
      bottom_y_ff <= bottom_y_in;
      row_ff      <= row_in;
      xt_ff       <= xt_in;
      xb_ff       <= xb_in;
      dist_a_ff   <= dist_a_in;
      dist_b_ff   <= dist_b_in;
      den_ff      <= den_in;
      acc_ff      <= acc_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      whole_ff    <= whole_in;
      lv_ff       <= lv_in;
      rv_ff       <= rv_in;
      le_ff       <= le_in;
      rs_ff       <= rs_in;
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_row_in   = out_row_ff;
      out_whole_in = out_whole_ff;
      out_lv_in    = out_lv_ff;
      out_rv_in    = out_rv_ff;
      out_le_in    = out_le_ff;
      out_rs_in    = out_rs_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (cmd.result_load) begin
         out_valid_in = 1'b1;
         out_row_in   = row_ff;
         out_whole_in = whole_ff;
         out_lv_in    = lv_ff;
         out_rv_in    = rv_ff;
         out_le_in    = le_ff;
         out_rs_in    = rs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_row_ff   <= out_row_in;
      out_whole_ff <= out_whole_in;
      out_lv_ff    <= out_lv_in;
      out_rv_ff    <= out_rv_in;
      out_le_ff    <= out_le_in;
      out_rs_ff    <= out_rs_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_row         = out_row_ff;
   assign rsp_whole_row   = out_whole_ff;
   assign rsp_left_valid  = out_lv_ff;
   assign rsp_left_end    = out_le_ff;
   assign rsp_right_valid = out_rv_ff;
   assign rsp_right_start = out_rs_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_CORNERS))
      else $error("vertex count above store depth");

   a_extremes_in_store: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> (CW'(top_ff) < count_ff) && (CW'(bottom_ff) < count_ff))
      else $error("top or bottom vertex outside loaded range");

   a_whole_excludes_sides: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_whole_ff |-> !out_lv_ff && !out_rv_ff)
      else $error("whole row reported with a side fill");

   a_left_positive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_lv_ff |-> out_le_ff > 0)
      else $error("left fill end not inside the row");

   a_div_in_span: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> den_ff != '0)
      else $error("division with empty edge span");

endmodule

`default_nettype wire
